@@ rtl/rme_pkg.sv @@
// ----------------------------------------------------------------------------
// rme_pkg
// Item types, action codes and status codes of the register map engine.
// ----------------------------------------------------------------------------
package rme_pkg;

	localparam logic [2:0] ACT_MAP      = 3'd0;
	localparam logic [2:0] ACT_RD_COIL  = 3'd1;
	localparam logic [2:0] ACT_WR_COIL  = 3'd2;
	localparam logic [2:0] ACT_WR_BITS  = 3'd3;
	localparam logic [2:0] ACT_RD_REGS  = 3'd4;
	localparam logic [2:0] ACT_WR_REG   = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_BAD_RUN   = 2'd2;
	localparam logic [1:0] ST_BAD_COUNT = 2'd3;

	localparam int COIL_BITS = 16;

	typedef struct packed {
		logic [2:0]  action;
		logic        space;
		logic [5:0]  slot;
		logic [15:0] address;
		logic [6:0]  count;
		logic [15:0] data_word;
		logic        last;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] read_value;
		logic        end_of_run;
	} rsp_t;

endpackage

@@ rtl/register_map_engine.sv @@
// ----------------------------------------------------------------------------
// register_map_engine
// Sparse coil and holding-register map of a bus slave with run access.
// ----------------------------------------------------------------------------
// An item is taken in S_IDLE and decoded in S_DISPATCH before its table
// walk: a coil lookup walks one coil slot per cycle, a register run lookup
// probes slot by slot through the register memory read port and reads back
// the run end of each matching slot whose end lies in the table. A register
// read run then emits its results through S_RD_WAIT and S_RD_EMIT. Items
// that continue an open write run go from dispatch straight to S_STEP.
// The block accepts no item while one is in progress; the result register
// lets the next item in while a result waits to be taken.
module register_map_engine #(
	parameter int COIL_ENTRIES = 8,
	parameter int REG_ENTRIES  = 64,
	parameter int MAX_RUN      = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rme_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rme_pkg::rsp_t rsp
);

	localparam int CI_W   = (COIL_ENTRIES > 1) ? $clog2(COIL_ENTRIES) : 1;
	localparam int RI_W   = (REG_ENTRIES > 1) ? $clog2(REG_ENTRIES) : 1;
	localparam int SW     = (CI_W > RI_W) ? CI_W : RI_W;
	localparam int EW     = ((SW > 7) ? SW : 7) + 1;
	localparam int PW_RAW = $clog2(REG_ENTRIES + COIL_ENTRIES + MAX_RUN + 1);
	localparam int PW     = (PW_RAW < 5) ? 5 : PW_RAW;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_COIL_SCAN, S_REG_PROBE, S_REG_MATCH,
		S_REG_ENDW, S_REG_END, S_STEP, S_RD_WAIT, S_RD_EMIT, S_EMIT
	} state_t;

	state_t            state_q;
	rme_pkg::req_t     item_q;
	rme_pkg::rsp_t     rsp_q;
	logic              rsp_valid_q;
	logic [1:0]        res_st_q;
	logic [15:0]       res_val_q;
	logic [SW-1:0]     scan_q;
	logic              any_q;
	logic [6:0]        j_q;
	logic              run_valid_q;
	logic [PW-1:0]     pos_q;
	logic [6:0]        rem_q;

	logic [15:0]       coil_addr_q [COIL_ENTRIES];
	logic [COIL_ENTRIES-1:0] coil_val_q;

	logic [15:0]       addr_mem [REG_ENTRIES];
	logic [15:0]       val_mem  [REG_ENTRIES];
	logic [REG_ENTRIES-1:0] addr_vld_q;
	logic [REG_ENTRIES-1:0] val_vld_q;
	logic [RI_W-1:0]   rd_idx_q;
	logic [15:0]       rd_addr_q;
	logic [15:0]       rd_val_q;
	logic              rd_addr_vld_q;
	logic              rd_val_vld_q;

	logic [15:0]       rd_addr_eff;
	logic [15:0]       rd_val_eff;
	logic [15:0]       cmp_a;
	logic [16:0]       cmp_b;
	logic [16:0]       key_end;
	logic              match;
	logic              bad_count;
	logic [EW-1:0]     end_idx;
	logic              end_in;
	logic              scan_reg_last;
	logic              out_free;
	logic [4:0]        step_n;
	logic [6:0]        new_rem;
	logic [COIL_ENTRIES-1:0] bit_en;
	logic [COIL_ENTRIES-1:0] bit_val;
	logic              addr_we;
	logic              val_we;
	logic [RI_W-1:0]   mem_wa;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign rd_addr_eff = rd_addr_vld_q ? rd_addr_q : 16'd0;
	assign rd_val_eff  = rd_val_vld_q ? rd_val_q : 16'd0;
	assign key_end     = {1'b0, item_q.address} + 17'(item_q.count) - 17'd1;
	assign bad_count   = (item_q.count == 7'd0) || (32'(item_q.count) > MAX_RUN);

	assign cmp_a = (state_q == S_COIL_SCAN) ? coil_addr_q[CI_W'(scan_q)] : rd_addr_eff;
	assign cmp_b = (state_q == S_REG_END) ? key_end : {1'b0, item_q.address};
	assign match = ({1'b0, cmp_a} == cmp_b);

	assign end_idx       = EW'(scan_q) + EW'(item_q.count) - EW'(1);
	assign end_in        = (32'(end_idx) < REG_ENTRIES);
	assign scan_reg_last = (scan_q == SW'(REG_ENTRIES - 1));

	always_comb begin
		step_n = 5'd1;
		if (item_q.action == rme_pkg::ACT_WR_BITS) begin
			step_n = (rem_q < 7'd16) ? rem_q[4:0] : 5'd16;
		end
		new_rem = (rem_q > 7'(step_n)) ? rem_q - 7'(step_n) : 7'd0;
	end

	always_comb begin
		logic [PW-1:0] off;
		for (int k = 0; k < COIL_ENTRIES; k++) begin
			off        = PW'(k) - pos_q;
			bit_en[k]  = (PW'(k) >= pos_q) && (off < PW'(step_n));
			bit_val[k] = item_q.data_word[off[3:0]];
		end
	end

	always_comb begin
		addr_we = 1'b0;
		val_we  = 1'b0;
		mem_wa  = RI_W'(item_q.slot);
		if (state_q == S_DISPATCH && item_q.action == rme_pkg::ACT_MAP && item_q.space &&
				32'(item_q.slot) < REG_ENTRIES) begin
			addr_we = 1'b1;
			val_we  = 1'b1;
		end
		if (state_q == S_STEP && item_q.action == rme_pkg::ACT_WR_REG &&
				32'(pos_q) < REG_ENTRIES) begin
			val_we = 1'b1;
			mem_wa = RI_W'(pos_q);
		end
	end

	always_ff @(posedge clk) begin
		if (addr_we) begin
			addr_mem[mem_wa] <= item_q.address;
		end
		if (val_we) begin
			val_mem[mem_wa] <= item_q.data_word;
		end
		rd_addr_q <= addr_mem[rd_idx_q];
		rd_val_q  <= val_mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_vld_q    <= '0;
			val_vld_q     <= '0;
			rd_addr_vld_q <= 1'b0;
			rd_val_vld_q  <= 1'b0;
		end else begin
			if (addr_we) begin
				addr_vld_q[mem_wa] <= 1'b1;
			end
			if (val_we) begin
				val_vld_q[mem_wa] <= 1'b1;
			end
			rd_addr_vld_q <= addr_vld_q[rd_idx_q];
			rd_val_vld_q  <= val_vld_q[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			run_valid_q <= 1'b0;
			pos_q       <= '0;
			rem_q       <= '0;
			coil_addr_q <= '{default: '0};
			coil_val_q  <= '0;
			item_q      <= '0;
			rsp_q       <= '0;
			res_st_q    <= rme_pkg::ST_OK;
			res_val_q   <= '0;
			scan_q      <= '0;
			any_q       <= 1'b0;
			j_q         <= '0;
			rd_idx_q    <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_EMIT && state_q != S_RD_EMIT) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						item_q  <= req;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					scan_q    <= '0;
					any_q     <= 1'b0;
					rd_idx_q  <= '0;
					res_val_q <= '0;
					res_st_q  <= rme_pkg::ST_OK;
					state_q   <= S_EMIT;
					case (item_q.action)
						rme_pkg::ACT_MAP: begin
							if (!item_q.space) begin
								if (32'(item_q.slot) < COIL_ENTRIES) begin
									coil_addr_q[CI_W'(item_q.slot)] <= item_q.address;
									coil_val_q[CI_W'(item_q.slot)]  <= item_q.data_word[0];
								end else begin
									res_st_q <= rme_pkg::ST_BAD_RUN;
								end
							end else if (32'(item_q.slot) >= REG_ENTRIES) begin
								res_st_q <= rme_pkg::ST_BAD_RUN;
							end
						end
						rme_pkg::ACT_RD_COIL, rme_pkg::ACT_WR_COIL: begin
							state_q <= S_COIL_SCAN;
						end
						rme_pkg::ACT_WR_BITS: begin
							if (run_valid_q) begin
								state_q <= S_STEP;
							end else if (bad_count) begin
								res_st_q <= rme_pkg::ST_BAD_COUNT;
							end else begin
								state_q <= S_COIL_SCAN;
							end
						end
						rme_pkg::ACT_RD_REGS: begin
							if (bad_count) begin
								res_st_q <= rme_pkg::ST_BAD_COUNT;
							end else begin
								state_q <= S_REG_PROBE;
							end
						end
						rme_pkg::ACT_WR_REG: begin
							if (run_valid_q) begin
								state_q <= S_STEP;
							end else if (bad_count) begin
								res_st_q <= rme_pkg::ST_BAD_COUNT;
							end else begin
								state_q <= S_REG_PROBE;
							end
						end
						default: begin
							state_q <= S_EMIT;
						end
					endcase
				end
				S_COIL_SCAN: begin
					if (match) begin
						case (item_q.action)
							rme_pkg::ACT_RD_COIL: begin
								res_val_q <= 16'(coil_val_q[CI_W'(scan_q)]);
								state_q   <= S_EMIT;
							end
							rme_pkg::ACT_WR_COIL: begin
								coil_val_q[CI_W'(scan_q)] <= (item_q.data_word != 16'd0);
								state_q <= S_EMIT;
							end
							default: begin
								pos_q   <= PW'(scan_q);
								rem_q   <= item_q.count;
								state_q <= S_STEP;
							end
						endcase
					end else if (scan_q == SW'(COIL_ENTRIES - 1)) begin
						res_st_q <= rme_pkg::ST_NOT_FOUND;
						state_q  <= S_EMIT;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_REG_PROBE: begin
					state_q <= S_REG_MATCH;
				end
				S_REG_MATCH: begin
					if (match) begin
						any_q <= 1'b1;
					end
					if (match && end_in) begin
						rd_idx_q <= RI_W'(end_idx);
						state_q  <= S_REG_ENDW;
					end else if (scan_reg_last) begin
						res_st_q <= (any_q || match) ? rme_pkg::ST_BAD_RUN
							: rme_pkg::ST_NOT_FOUND;
						state_q  <= S_EMIT;
					end else begin
						scan_q   <= scan_q + 1'b1;
						rd_idx_q <= RI_W'(scan_q + 1'b1);
						state_q  <= S_REG_PROBE;
					end
				end
				S_REG_ENDW: begin
					state_q <= S_REG_END;
				end
				S_REG_END: begin
					if (match) begin
						if (item_q.action == rme_pkg::ACT_RD_REGS) begin
							j_q      <= '0;
							rd_idx_q <= RI_W'(scan_q);
							state_q  <= S_RD_WAIT;
						end else begin
							pos_q   <= PW'(scan_q);
							rem_q   <= item_q.count;
							state_q <= S_STEP;
						end
					end else if (scan_reg_last) begin
						res_st_q <= rme_pkg::ST_BAD_RUN;
						state_q  <= S_EMIT;
					end else begin
						scan_q   <= scan_q + 1'b1;
						rd_idx_q <= RI_W'(scan_q + 1'b1);
						state_q  <= S_REG_PROBE;
					end
				end
				S_STEP: begin
					if (item_q.action == rme_pkg::ACT_WR_BITS) begin
						for (int k = 0; k < COIL_ENTRIES; k++) begin
							if (bit_en[k]) begin
								coil_val_q[k] <= bit_val[k];
							end
						end
					end
					if (new_rem != 7'd0 && !item_q.last) begin
						run_valid_q <= 1'b1;
						pos_q       <= pos_q + PW'(step_n);
						rem_q       <= new_rem;
					end else begin
						run_valid_q <= 1'b0;
						pos_q       <= '0;
						rem_q       <= '0;
					end
					res_st_q <= rme_pkg::ST_OK;
					state_q  <= S_EMIT;
				end
				S_RD_WAIT: begin
					state_q <= S_RD_EMIT;
				end
				S_RD_EMIT: begin
					if (out_free) begin
						rsp_valid_q      <= 1'b1;
						rsp_q.status     <= rme_pkg::ST_OK;
						rsp_q.read_value <= rd_val_eff;
						rsp_q.end_of_run <= (j_q + 7'd1 == item_q.count);
						if (j_q + 7'd1 == item_q.count) begin
							state_q <= S_IDLE;
						end else begin
							j_q      <= j_q + 7'd1;
							rd_idx_q <= rd_idx_q + 1'b1;
							state_q  <= S_RD_WAIT;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						rsp_valid_q      <= 1'b1;
						rsp_q.status     <= res_st_q;
						rsp_q.read_value <= res_val_q;
						rsp_q.end_of_run <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ tb/register_map_checker.sv @@
// ----------------------------------------------------------------------------
// register_map_checker
// Watches the request and response channels of the register map engine,
// predicts the responses of each accepted item and compares them in order.
// ----------------------------------------------------------------------------
module register_map_checker #(
	parameter int COIL_ENTRIES = 8,
	parameter int REG_ENTRIES  = 64,
	parameter int MAX_RUN      = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  rme_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  rme_pkg::rsp_t rsp,
	output int            errors,
	output int            pending
);

	logic [15:0]   coil_addr [COIL_ENTRIES];
	logic          coil_val  [COIL_ENTRIES];
	logic [15:0]   reg_addr  [REG_ENTRIES];
	logic [15:0]   reg_val   [REG_ENTRIES];
	logic          run_open;
	int            run_pos;
	int            run_left;
	rme_pkg::rsp_t rsp_queue [$];

	function automatic rme_pkg::rsp_t mk(logic [1:0] st, logic [15:0] v, logic e);
		rme_pkg::rsp_t r;
		r.status = st;
		r.read_value = v;
		r.end_of_run = e;
		return r;
	endfunction

	function automatic int coil_slot(logic [15:0] a);
		for (int i = 0; i < COIL_ENTRIES; i++)
			if (coil_addr[i] == a)
				return i;
		return -1;
	endfunction

	// returns status; slot through base
	function automatic logic [1:0] reg_run(logic [15:0] a, int cnt, output int base);
		logic any;
		int e;
		any = 1'b0;
		base = 0;
		for (int i = 0; i < REG_ENTRIES; i++) begin
			if (reg_addr[i] == a) begin
				any = 1'b1;
				e = i + cnt - 1;
				if (e < REG_ENTRIES && 32'(reg_addr[e]) == 32'(a) + cnt - 1) begin
					base = i;
					return rme_pkg::ST_OK;
				end
			end
		end
		return any ? rme_pkg::ST_BAD_RUN : rme_pkg::ST_NOT_FOUND;
	endfunction

	function automatic void close_step(int n, logic lst);
		run_pos += n;
		run_left = (run_left > n) ? run_left - n : 0;
		run_open = (run_left != 0) && !lst;
		if (!run_open) begin
			run_pos = 0;
			run_left = 0;
		end
	endfunction

	task automatic predict_item(rme_pkg::req_t q);
		int idx;
		int n;
		int cnt;
		logic [1:0] st;
		logic bad;
		cnt = q.count;
		bad = (cnt == 0 || cnt > MAX_RUN);
		case (q.action)
			rme_pkg::ACT_MAP: begin
				if (q.space == 1'b0) begin
					if (q.slot >= COIL_ENTRIES) begin
						rsp_queue.push_back(mk(rme_pkg::ST_BAD_RUN, 16'd0, 1'b1));
					end else begin
						coil_addr[q.slot] = q.address;
						coil_val[q.slot] = q.data_word[0];
						rsp_queue.push_back(mk(rme_pkg::ST_OK, 16'd0, 1'b1));
					end
				end else begin
					if (q.slot >= REG_ENTRIES) begin
						rsp_queue.push_back(mk(rme_pkg::ST_BAD_RUN, 16'd0, 1'b1));
					end else begin
						reg_addr[q.slot] = q.address;
						reg_val[q.slot] = q.data_word;
						rsp_queue.push_back(mk(rme_pkg::ST_OK, 16'd0, 1'b1));
					end
				end
			end
			rme_pkg::ACT_RD_COIL, rme_pkg::ACT_WR_COIL: begin
				idx = coil_slot(q.address);
				if (idx < 0) begin
					rsp_queue.push_back(mk(rme_pkg::ST_NOT_FOUND, 16'd0, 1'b1));
				end else if (q.action == rme_pkg::ACT_RD_COIL) begin
					rsp_queue.push_back(mk(rme_pkg::ST_OK, 16'(coil_val[idx]), 1'b1));
				end else begin
					coil_val[idx] = (q.data_word != 16'd0);
					rsp_queue.push_back(mk(rme_pkg::ST_OK, 16'd0, 1'b1));
				end
			end
			rme_pkg::ACT_WR_BITS: begin
				if (!run_open) begin
					if (bad) begin
						rsp_queue.push_back(mk(rme_pkg::ST_BAD_COUNT, 16'd0, 1'b1));
						return;
					end
					idx = coil_slot(q.address);
					if (idx < 0) begin
						rsp_queue.push_back(mk(rme_pkg::ST_NOT_FOUND, 16'd0, 1'b1));
						return;
					end
					run_pos = idx;
					run_left = cnt;
				end
				n = run_left < rme_pkg::COIL_BITS ? run_left : rme_pkg::COIL_BITS;
				for (int j = 0; j < n; j++)
					if (run_pos + j < COIL_ENTRIES)
						coil_val[run_pos + j] = q.data_word[j];
				close_step(n, q.last);
				rsp_queue.push_back(mk(rme_pkg::ST_OK, 16'd0, 1'b1));
			end
			rme_pkg::ACT_RD_REGS: begin
				if (bad) begin
					rsp_queue.push_back(mk(rme_pkg::ST_BAD_COUNT, 16'd0, 1'b1));
					return;
				end
				st = reg_run(q.address, cnt, idx);
				if (st != rme_pkg::ST_OK) begin
					rsp_queue.push_back(mk(st, 16'd0, 1'b1));
					return;
				end
				for (int j = 0; j < cnt; j++)
					rsp_queue.push_back(mk(rme_pkg::ST_OK, reg_val[idx + j], j + 1 == cnt));
			end
			rme_pkg::ACT_WR_REG: begin
				if (!run_open) begin
					if (bad) begin
						rsp_queue.push_back(mk(rme_pkg::ST_BAD_COUNT, 16'd0, 1'b1));
						return;
					end
					st = reg_run(q.address, cnt, idx);
					if (st != rme_pkg::ST_OK) begin
						rsp_queue.push_back(mk(st, 16'd0, 1'b1));
						return;
					end
					run_pos = idx;
					run_left = cnt;
				end
				if (run_pos < REG_ENTRIES)
					reg_val[run_pos] = q.data_word;
				close_step(1, q.last);
				rsp_queue.push_back(mk(rme_pkg::ST_OK, 16'd0, 1'b1));
			end
			default: rsp_queue.push_back(mk(rme_pkg::ST_OK, 16'd0, 1'b1));
		endcase
	endtask

	always @(posedge clk) begin
		rme_pkg::rsp_t exp_rsp;
		if (!arst_n) begin
			errors = 0;
			for (int i = 0; i < COIL_ENTRIES; i++) begin
				coil_addr[i] = 16'd0;
				coil_val[i] = 1'b0;
			end
			for (int i = 0; i < REG_ENTRIES; i++) begin
				reg_addr[i] = 16'd0;
				reg_val[i] = 16'd0;
			end
			run_open = 1'b0;
			run_pos = 0;
			run_left = 0;
			rsp_queue.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (rsp_queue.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected response %p", rsp);
				end else begin
					exp_rsp = rsp_queue.pop_front();
					if (rsp.status !== exp_rsp.status || rsp.read_value !== exp_rsp.read_value
					    || rsp.end_of_run !== exp_rsp.end_of_run) begin
						errors++;
						if (errors <= 10)
							$display("response mismatch: expected %p, got %p", exp_rsp, rsp);
					end
				end
			end
			if (req_valid && !req_stall)
				predict_item(req);
		end
		pending = rsp_queue.size();
	end

endmodule

@@ tb/tb_register_map_engine.sv @@
// ----------------------------------------------------------------------------
// tb_register_map_engine
// Drives directed and random items into the register map engine under
// several idle and stall phases; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_register_map_engine;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	rme_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	rme_pkg::rsp_t rsp;
	int            errors;
	int            pending;
	int            send_idle;
	int            recv_idle;
	logic [15:0]   reg_base;

	register_map_engine u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	register_map_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		if (!arst_n)
			rsp_stall <= 1'b0;
		else
			rsp_stall <= ($urandom_range(99) < recv_idle);
	end

	task automatic send(rme_pkg::req_t q);
		logic acc;
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= q;
		req_valid <= 1'b1;
		do begin
			acc = !req_stall;
			@(negedge clk);
		end while (!acc);
	endtask

	function automatic rme_pkg::req_t item(logic [2:0] a, logic s, logic [5:0] sl,
	                                       logic [15:0] ad, logic [6:0] c, logic [15:0] d,
	                                       logic l);
		rme_pkg::req_t q;
		q.action = a;
		q.space = s;
		q.slot = sl;
		q.address = ad;
		q.count = c;
		q.data_word = d;
		q.last = l;
		return q;
	endfunction

	function automatic rme_pkg::req_t noise();
		rme_pkg::req_t q;
		logic [63:0] r;
		r = {$urandom, $urandom};
		q = r[$bits(rme_pkg::req_t)-1:0];
		if ($urandom_range(3) != 0)
			q.count = 7'($urandom_range(8));
		return q;
	endfunction

	task automatic drain();
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	initial begin
		int cnt;
		int n;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		send_idle = 0;
		recv_idle = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		send(item(rme_pkg::ACT_RD_COIL, 1'b0, 6'd0, 16'h0000, 7'd0, 16'h0000, 1'b0));
		send(item(rme_pkg::ACT_RD_COIL, 1'b0, 6'd0, 16'hFFFF, 7'd0, 16'h0000, 1'b0));
		send(item(rme_pkg::ACT_MAP, 1'b0, 6'd7, 16'hFFFF, 7'd0, 16'hFFFF, 1'b1));
		send(item(rme_pkg::ACT_MAP, 1'b0, 6'd8, 16'h1234, 7'd0, 16'h0001, 1'b0));
		send(item(rme_pkg::ACT_MAP, 1'b1, 6'd63, 16'hFFFF, 7'd0, 16'hFFFF, 1'b0));
		send(item(rme_pkg::ACT_RD_COIL, 1'b0, 6'd0, 16'hFFFF, 7'd0, 16'h0000, 1'b0));
		send(item(rme_pkg::ACT_WR_COIL, 1'b0, 6'd0, 16'hFFFF, 7'd0, 16'h0000, 1'b0));
		send(item(rme_pkg::ACT_WR_COIL, 1'b0, 6'd0, 16'h7777, 7'd0, 16'h0001, 1'b0));
		send(item(rme_pkg::ACT_RD_REGS, 1'b0, 6'd0, 16'hFFFF, 7'd0, 16'h0000, 1'b0));
		send(item(rme_pkg::ACT_RD_REGS, 1'b0, 6'd0, 16'hFFFF, 7'd65, 16'h0000, 1'b0));
		send(item(rme_pkg::ACT_RD_REGS, 1'b0, 6'd0, 16'hFFFF, 7'd127, 16'h0000, 1'b0));
		send(item(rme_pkg::ACT_RD_REGS, 1'b0, 6'd0, 16'hFFFF, 7'd1, 16'h0000, 1'b0));
		send(item(rme_pkg::ACT_RD_REGS, 1'b0, 6'd0, 16'hFFFF, 7'd2, 16'h0000, 1'b0));
		send(item(rme_pkg::ACT_RD_REGS, 1'b0, 6'd0, 16'h4321, 7'd1, 16'h0000, 1'b0));
		send(item(rme_pkg::ACT_RD_REGS, 1'b0, 6'd0, 16'h0000, 7'd64, 16'h0000, 1'b0));
		send(item(rme_pkg::ACT_WR_REG, 1'b0, 6'd0, 16'h0000, 7'd3, 16'hA5A5, 1'b0));
		send(item(rme_pkg::ACT_WR_REG, 1'b0, 6'd0, 16'h9999, 7'd9, 16'h5A5A, 1'b1));
		send(item(rme_pkg::ACT_WR_BITS, 1'b0, 6'd0, 16'h0000, 7'd64, 16'hAAAA, 1'b0));
		send(item(rme_pkg::ACT_RD_COIL, 1'b0, 6'd0, 16'h0000, 7'd0, 16'h0000, 1'b0));
		send(item(rme_pkg::ACT_WR_BITS, 1'b0, 6'd0, 16'h0000, 7'd0, 16'h5555, 1'b0));
		send(item(rme_pkg::ACT_WR_REG, 1'b0, 6'd0, 16'h0000, 7'd0, 16'hFFFF, 1'b0));
		send(item(3'd6, 1'b1, 6'd63, 16'hFFFF, 7'd127, 16'hFFFF, 1'b1));
		send(item(3'd7, 1'b0, 6'd0, 16'h0000, 7'd0, 16'h0000, 1'b0));
		send(item(rme_pkg::ACT_WR_BITS, 1'b0, 6'd0, 16'h0000, 7'd0, 16'h0000, 1'b1));
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_idle = 0;  end
				1: begin send_idle = 68; recv_idle = 0;  end
				2: begin send_idle = 0;  recv_idle = 68; end
				default: begin send_idle = 8; recv_idle = 8; end
			endcase
			// lay out a contiguous register block and coils
			reg_base = 16'($urandom);
			for (int s = 0; s < 8; s++)
				send(item(rme_pkg::ACT_MAP, 1'b1, 6'(s), reg_base + 16'(s), 7'd0,
				          16'($urandom), 1'b0));
			for (int s = 0; s < 8; s++)
				send(item(rme_pkg::ACT_MAP, 1'b0, 6'(s), reg_base + 16'(s), 7'd0,
				          16'($urandom), 1'b0));
			for (int k = 0; k < 40; k++) begin
				case ($urandom_range(9))
					0, 1: begin
						cnt = $urandom_range(1, 8 - (k % 8));
						send(item(rme_pkg::ACT_RD_REGS, 1'b0, 6'd0, reg_base + 16'(k % 8),
						          7'(cnt), 16'h0000, 1'b0));
					end
					2, 3: begin
						cnt = $urandom_range(1, 4);
						n = $urandom_range(0, 7);
						for (int j = 0; j < cnt; j++)
							send(item(rme_pkg::ACT_WR_REG, 1'b0, 6'd0, reg_base + 16'(n),
							          7'(cnt), 16'($urandom),
							          (j == cnt - 1) && ($urandom_range(1) != 0)));
						if (n + cnt > 8)
							send(item(rme_pkg::ACT_WR_REG, 1'b0, 6'd0, 16'h0000, 7'd0,
							          16'h0000, 1'b1));
					end
					4: begin
						send(item(rme_pkg::ACT_WR_BITS, 1'b0, 6'd0,
						          reg_base + 16'($urandom_range(7)),
						          7'($urandom_range(1, 40)), 16'($urandom), 1'b0));
						send(item(rme_pkg::ACT_WR_BITS, 1'b0, 6'd0, 16'h0000, 7'd0,
						          16'($urandom), 1'b1));
					end
					5, 6: send(item(($urandom_range(1) != 0) ? rme_pkg::ACT_RD_COIL
					                                          : rme_pkg::ACT_WR_COIL,
					                 1'b0, 6'd0, reg_base + 16'($urandom_range(8)), 7'd0,
					                 16'($urandom_range(1)), 1'b0));
					7: send(item(rme_pkg::ACT_MAP, 1'($urandom_range(1)),
					             6'($urandom_range(63)), reg_base + 16'($urandom_range(9)),
					             7'd0, 16'($urandom), 1'b0));
					default: send(noise());
				endcase
			end
			// let the block drain fully before the next phase
			drain();
		end

		// large read across the whole register table
		for (int s = 0; s < 64; s++)
			send(item(rme_pkg::ACT_MAP, 1'b1, 6'(s), 16'hFFC0 + 16'(s), 7'd0,
			          16'($urandom), 1'b0));
		send(item(rme_pkg::ACT_RD_REGS, 1'b0, 6'd0, 16'hFFC0, 7'd64, 16'h0000, 1'b0));
		send(item(rme_pkg::ACT_RD_REGS, 1'b0, 6'd0, 16'hFFC1, 7'd64, 16'h0000, 1'b0));
		drain();

		if (errors == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#20000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/rme_pkg.sv
rtl/register_map_engine.sv
tb/register_map_checker.sv
tb/tb_register_map_engine.sv
